[design/rgbyuv_pkg.sv]
package rgbyuv_pkg;

   // Field widths of the pixel and result beats.
   localparam int unsigned COMPONENT_W = 8;
   localparam int unsigned POSITION_W  = 12;
   localparam int unsigned DIM_REG_W   = 13;

   // Width of the fixed-point sums: every sum stays below 2**24.
   localparam int unsigned SUM_W  = 24;
   localparam int unsigned FRAC_W = 16;

   // Coefficients rounded to unsigned Q0.16.
   localparam logic [FRAC_W-1:0] COEF_Y_R  = 16'd16843;
   localparam logic [FRAC_W-1:0] COEF_Y_G  = 16'd33030;
   localparam logic [FRAC_W-1:0] COEF_Y_B  = 16'd6423;
   localparam logic [FRAC_W-1:0] COEF_CB_R = 16'd9699;
   localparam logic [FRAC_W-1:0] COEF_CB_G = 16'd19071;
   localparam logic [FRAC_W-1:0] COEF_CB_B = 16'd28770;
   localparam logic [FRAC_W-1:0] COEF_CR_R = 16'd28770;
   localparam logic [FRAC_W-1:0] COEF_CR_G = 16'd24117;
   localparam logic [FRAC_W-1:0] COEF_CR_B = 16'd4653;

   // Chroma offset of 128, also the neutral chroma value.
   localparam logic [COMPONENT_W-1:0] CHROMA_NEUTRAL = 8'd128;
   localparam logic [SUM_W-1:0]       CHROMA_OFFSET  = 24'd8388608;

   // Configuration register indexes and reset values.
   localparam logic CSR_LINE_WIDTH   = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [DIM_REG_W-1:0] LINE_WIDTH_RESET   = 13'd640;
   localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic [COMPONENT_W-1:0] red;
      logic [COMPONENT_W-1:0] green;
      logic [COMPONENT_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [COMPONENT_W-1:0] luma;
      logic [COMPONENT_W-1:0] chroma_blue;
      logic [COMPONENT_W-1:0] chroma_red;
   } colour_type;

endpackage

[design/rgbyuv_req_if.sv]
interface rgbyuv_req_if;
   logic                                valid;
   logic                                ready;
   logic [rgbyuv_pkg::COMPONENT_W-1:0] red;
   logic [rgbyuv_pkg::COMPONENT_W-1:0] green;
   logic [rgbyuv_pkg::COMPONENT_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[design/rgbyuv_rsp_if.sv]
interface rgbyuv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rgbyuv_pkg::COMPONENT_W-1:0] luma;
   logic [rgbyuv_pkg::COMPONENT_W-1:0] chroma_blue;
   logic [rgbyuv_pkg::COMPONENT_W-1:0] chroma_red;
   logic                                chroma_valid;
   logic [rgbyuv_pkg::POSITION_W-1:0]  column;
   logic [rgbyuv_pkg::POSITION_W-1:0]  row;
   logic                                frame_last;

   modport source (output valid, output luma, output chroma_blue, output chroma_red,
                   output chroma_valid, output column, output row, output frame_last,
                   input ready);
   modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                   input chroma_valid, input column, input row, input frame_last,
                   output ready);
endinterface

[design/rgbyuv_matrix.sv]
// BT.601 colour matrix in Q0.16; results are truncated, never negative.
module rgbyuv_matrix (
   input  rgbyuv_pkg::pixel_type  pixel,
   output rgbyuv_pkg::colour_type colour
);

   logic [rgbyuv_pkg::SUM_W-1:0] r_ext;
   logic [rgbyuv_pkg::SUM_W-1:0] g_ext;
   logic [rgbyuv_pkg::SUM_W-1:0] b_ext;
   logic [rgbyuv_pkg::SUM_W-1:0] y_sum;
   logic [rgbyuv_pkg::SUM_W-1:0] cb_sum;
   logic [rgbyuv_pkg::SUM_W-1:0] cr_sum;

   assign r_ext = rgbyuv_pkg::SUM_W'(pixel.red);
   assign g_ext = rgbyuv_pkg::SUM_W'(pixel.green);
   assign b_ext = rgbyuv_pkg::SUM_W'(pixel.blue);

   // The chroma sums add the offset and the positive term first, so no partial
   // sum wraps modulo 2**24, and the final value is always in range.
   always_comb begin
      y_sum  = r_ext * rgbyuv_pkg::SUM_W'(rgbyuv_pkg::COEF_Y_R)
             + g_ext * rgbyuv_pkg::SUM_W'(rgbyuv_pkg::COEF_Y_G)
             + b_ext * rgbyuv_pkg::SUM_W'(rgbyuv_pkg::COEF_Y_B);
      cb_sum = rgbyuv_pkg::CHROMA_OFFSET
             + b_ext * rgbyuv_pkg::SUM_W'(rgbyuv_pkg::COEF_CB_B)
             - r_ext * rgbyuv_pkg::SUM_W'(rgbyuv_pkg::COEF_CB_R)
             - g_ext * rgbyuv_pkg::SUM_W'(rgbyuv_pkg::COEF_CB_G);
      cr_sum = rgbyuv_pkg::CHROMA_OFFSET
             + r_ext * rgbyuv_pkg::SUM_W'(rgbyuv_pkg::COEF_CR_R)
             - g_ext * rgbyuv_pkg::SUM_W'(rgbyuv_pkg::COEF_CR_G)
             - b_ext * rgbyuv_pkg::SUM_W'(rgbyuv_pkg::COEF_CR_B);
   end

   assign colour.luma        = y_sum[rgbyuv_pkg::SUM_W-1:rgbyuv_pkg::FRAC_W];
   assign colour.chroma_blue = cb_sum[rgbyuv_pkg::SUM_W-1:rgbyuv_pkg::FRAC_W];
   assign colour.chroma_red  = cr_sum[rgbyuv_pkg::SUM_W-1:rgbyuv_pkg::FRAC_W];

endmodule

[design/rgb_to_yuv420_converter_unit.sv]
// The result beat of an accepted pixel beat is valid in the cycle after it is taken.
// Throughput: one pixel per cycle; a new beat is taken whenever the result
// register is empty or its beat is taken in the same cycle.
// Reset (synchronous, active high) clears the column and row counters and the
// result valid flag, and returns line width and frame height to 640 and 480.

// The block converts one RGB pixel per beat to BT.601 luma and, on pixels
// where both column and row are odd, point-sampled Cb and Cr offset by 128.
// On every other pixel the chroma fields carry the neutral value 128.
// All arithmetic for a pixel sits between the input port and a single result
// register, so the only loop in the design is the raster position counter.
module rgb_to_yuv420_converter_unit #(
   parameter int unsigned MAX_DIMENSION = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   rgbyuv_req_if.sink                          req_chan,
   rgbyuv_rsp_if.source                        rsp_chan,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [rgbyuv_pkg::DIM_REG_W-1:0]    csr_write_data
);

   // Counters hold positions up to MAX_DIMENSION - 1; dimensions need one bit
   // more so that MAX_DIMENSION itself fits. Comparisons against the 13-bit
   // registers are done at the wider of the two widths.
   localparam int unsigned CNT_W = $clog2(MAX_DIMENSION);
   localparam int unsigned DIM_W = CNT_W + 1;
   localparam int unsigned CMP_W = (DIM_W > rgbyuv_pkg::DIM_REG_W) ? DIM_W
                                                                  : rgbyuv_pkg::DIM_REG_W;
   localparam int unsigned EXT_W = (CNT_W > rgbyuv_pkg::POSITION_W) ? CNT_W
                                                                   : rgbyuv_pkg::POSITION_W;

   // Configuration registers.
   logic [rgbyuv_pkg::DIM_REG_W-1:0] line_width_ff;
   logic [rgbyuv_pkg::DIM_REG_W-1:0] frame_height_ff;

   // Raster position of the next pixel.
   logic [CNT_W-1:0] col_ff;
   logic [CNT_W-1:0] col_in;
   logic [CNT_W-1:0] row_ff;
   logic [CNT_W-1:0] row_in;

   // Result register.
   logic                                out_valid_ff;
   logic                                out_valid_in;
   rgbyuv_pkg::colour_type              out_colour_ff;
   rgbyuv_pkg::colour_type              out_colour_in;
   logic                                out_cvalid_ff;
   logic [rgbyuv_pkg::POSITION_W-1:0]  out_col_ff;
   logic [rgbyuv_pkg::POSITION_W-1:0]  out_row_ff;
   logic                                out_last_ff;

   logic                   accept;
   logic [DIM_W-1:0]       width_eff;
   logic [DIM_W-1:0]       height_eff;
   logic [DIM_W-1:0]       col_next;
   logic [DIM_W-1:0]       row_next;
   logic                   last_col;
   logic                   last_row;
   logic                   chroma_site;
   logic [EXT_W-1:0]       col_ext;
   logic [EXT_W-1:0]       row_ext;
   rgbyuv_pkg::pixel_type  pixel;
   rgbyuv_pkg::colour_type colour;

   // A zero dimension counts as one, an oversize one as MAX_DIMENSION.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [rgbyuv_pkg::DIM_REG_W-1:0] v);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(v);
      if (wide == '0) begin
         return DIM_W'(1);
      end else if (wide > CMP_W'(MAX_DIMENSION)) begin
         return DIM_W'(MAX_DIMENSION);
      end
      return DIM_W'(wide);
   endfunction

   // The result register takes a new beat when it is empty or being drained.
   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign width_eff  = clamp_dim(line_width_ff);
   assign height_eff = clamp_dim(frame_height_ff);

   // After a shrink mid-frame a counter may already sit beyond the new last
   // position; the >= compare makes that pixel last in its line or frame.
   assign col_next    = DIM_W'(col_ff) + DIM_W'(1);
   assign row_next    = DIM_W'(row_ff) + DIM_W'(1);
   assign last_col    = col_next >= width_eff;
   assign last_row    = row_next >= height_eff;
   assign chroma_site = col_ff[0] && row_ff[0];

   assign pixel.red   = req_chan.red;
   assign pixel.green = req_chan.green;
   assign pixel.blue  = req_chan.blue;

   rgbyuv_matrix u_matrix (
      .pixel  (pixel),
      .colour (colour)
   );

   always_comb begin
      out_colour_in = colour;
      if (!chroma_site) begin
         out_colour_in.chroma_blue = rgbyuv_pkg::CHROMA_NEUTRAL;
         out_colour_in.chroma_red  = rgbyuv_pkg::CHROMA_NEUTRAL;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : CNT_W'(row_next);
         end else begin
            col_in = CNT_W'(col_next);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Positions are reported modulo 4096.
   assign col_ext = EXT_W'(col_ff);
   assign row_ext = EXT_W'(row_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= rgbyuv_pkg::LINE_WIDTH_RESET;
         frame_height_ff <= rgbyuv_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rgbyuv_pkg::CSR_LINE_WIDTH:   line_width_ff   <= csr_write_data;
            rgbyuv_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload of the result beat needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         out_colour_ff <= out_colour_in;
         out_cvalid_ff <= chroma_site;
         out_col_ff    <= col_ext[rgbyuv_pkg::POSITION_W-1:0];
         out_row_ff    <= row_ext[rgbyuv_pkg::POSITION_W-1:0];
         out_last_ff   <= last_col && last_row;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.luma         = out_colour_ff.luma;
   assign rsp_chan.chroma_blue  = out_colour_ff.chroma_blue;
   assign rsp_chan.chroma_red   = out_colour_ff.chroma_red;
   assign rsp_chan.chroma_valid = out_cvalid_ff;
   assign rsp_chan.column       = out_col_ff;
   assign rsp_chan.row          = out_row_ff;
   assign rsp_chan.frame_last   = out_last_ff;

`ifndef SYNTHESIS
   // Chroma is only given at odd column and odd row.
   a_chroma_site: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.chroma_valid) |-> (rsp_chan.column[0] && rsp_chan.row[0]))
      else $error("chroma given away from an odd column and odd row");

   // Non-chroma pixels carry neutral chroma.
   a_neutral: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.chroma_valid) |->
      (rsp_chan.chroma_blue == rgbyuv_pkg::CHROMA_NEUTRAL &&
       rsp_chan.chroma_red == rgbyuv_pkg::CHROMA_NEUTRAL))
      else $error("chroma not neutral on a luma-only pixel");

   // Luma without the +16 offset never exceeds 219.
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.luma <= 8'd219))
      else $error("luma out of range");

   // The raster position restarts at the origin after reset.
   a_reset_origin: assert property (@(posedge clock)
      $past(reset) |-> (col_ff == '0 && row_ff == '0 && !out_valid_ff))
      else $error("position or result valid not cleared by reset");
`endif

endmodule

[verif/rgb_to_yuv420_converter_unit_test.sv]
`timescale 1ns / 1ps

// Testbench for the RGB to YUV 4:2:0 converter.
//
// Pixel beats go in through the request channel and every accepted beat is run
// through a local model of the converter. The model keeps its own raster
// counters and its own copies of the two dimension registers. The result of the
// model goes onto a queue of expected results. Each result beat that the block
// hands out is compared, field by field, with the oldest entry of that queue.
// Both channels idle at random. The receiver also holds off once for a long
// stretch so that the block fills up and has to stall its input.
module rgb_to_yuv420_converter_unit_test;

   // Clock period is 12 ns, split evenly between the high and low phases.
   localparam int unsigned HALF_PERIOD     = 6;
   // The converter has a single result register, which these drain cycles cover.
   localparam int unsigned DRAIN_CYCLES    = 4;
   // Cycles without any accepted beat before the run is declared hung. This is
   // well above the long receiver hold-off and any run of random idle cycles.
   localparam int unsigned STALL_LIMIT     = 2000;
   localparam int unsigned HOLD_OFF_CYCLES = 64;
   localparam int unsigned RANDOM_PIXELS   = 1000;
   localparam int unsigned IDLE_PERCENT    = 27;

   // Our own view of the arithmetic: Q0.16 coefficients and the chroma offset.
   localparam int unsigned Y_R  = 16843;
   localparam int unsigned Y_G  = 33030;
   localparam int unsigned Y_B  = 6423;
   localparam int unsigned CB_R = 9699;
   localparam int unsigned CB_G = 19071;
   localparam int unsigned CB_B = 28770;
   localparam int unsigned CR_R = 28770;
   localparam int unsigned CR_G = 24117;
   localparam int unsigned CR_B = 4653;
   localparam int unsigned CHROMA_MID    = 128;
   localparam int unsigned DIMENSION_MAX = 4096;
   localparam int unsigned WIDTH_AT_RESET  = 640;
   localparam int unsigned HEIGHT_AT_RESET = 480;

   // One result beat as the converter should produce it.
   typedef struct packed {
      logic [rgbyuv_pkg::COMPONENT_W-1:0] luma;
      logic [rgbyuv_pkg::COMPONENT_W-1:0] chroma_blue;
      logic [rgbyuv_pkg::COMPONENT_W-1:0] chroma_red;
      logic                               chroma_valid;
      logic [rgbyuv_pkg::POSITION_W-1:0]  column;
      logic [rgbyuv_pkg::POSITION_W-1:0]  row;
      logic                               frame_last;
   } yuv_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic [rgbyuv_pkg::DIM_REG_W-1:0] csr_write_data;

   rgbyuv_req_if req_bus ();
   rgbyuv_rsp_if rsp_bus ();

   rgb_to_yuv420_converter_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Model state: the dimension registers as written and the raster position.
   logic [rgbyuv_pkg::DIM_REG_W-1:0] line_width_shadow =
      rgbyuv_pkg::DIM_REG_W'(WIDTH_AT_RESET);
   logic [rgbyuv_pkg::DIM_REG_W-1:0] frame_height_shadow =
      rgbyuv_pkg::DIM_REG_W'(HEIGHT_AT_RESET);
   logic [rgbyuv_pkg::POSITION_W-1:0] column_position = '0;
   logic [rgbyuv_pkg::POSITION_W-1:0] row_position    = '0;

   yuv_beat_type expected_yuv[$];
   int unsigned mismatch_count = 0;

   // Steady flow switches off the random idling on both sides.
   bit steady_flow      = 1'b0;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_off_request = 1'b0;

   // A dimension of zero behaves as one, and anything above the largest
   // supported size behaves as that size.
   function automatic int unsigned clamp_dimension(
      input logic [rgbyuv_pkg::DIM_REG_W-1:0] value);
      if (value == 0)
         return 1;
      if (value > DIMENSION_MAX)
         return DIMENSION_MAX;
      return 32'(value);
   endfunction

   // Works out the result for one accepted pixel and advances the raster
   // position. A position at or past the last column (or row) counts as last,
   // which covers a dimension shrunk in the middle of a line or frame.
   function automatic yuv_beat_type convert_pixel(input rgbyuv_pkg::pixel_type px);
      yuv_beat_type beat;
      int unsigned  w;
      int unsigned  h;
      int unsigned  r;
      int unsigned  g;
      int unsigned  b;
      int unsigned  luma_sum;
      int unsigned  cb_sum;
      int unsigned  cr_sum;
      bit           last_column;
      bit           last_row;
      w = clamp_dimension(line_width_shadow);
      h = clamp_dimension(frame_height_shadow);
      r = px.red;
      g = px.green;
      b = px.blue;
      last_column = (32'(column_position) + 32'd1) >= w;
      last_row    = (32'(row_position) + 32'd1) >= h;
      luma_sum = Y_R * r + Y_G * g + Y_B * b;
      beat.luma         = rgbyuv_pkg::COMPONENT_W'(luma_sum >> 16);
      beat.chroma_valid = column_position[0] & row_position[0];
      beat.chroma_blue  = rgbyuv_pkg::COMPONENT_W'(CHROMA_MID);
      beat.chroma_red   = rgbyuv_pkg::COMPONENT_W'(CHROMA_MID);
      if (beat.chroma_valid) begin
         // The offset keeps both sums positive, so the shift truncates.
         cb_sum = (CHROMA_MID << 16) + CB_B * b - CB_R * r - CB_G * g;
         cr_sum = (CHROMA_MID << 16) + CR_R * r - CR_G * g - CR_B * b;
         beat.chroma_blue = rgbyuv_pkg::COMPONENT_W'(cb_sum >> 16);
         beat.chroma_red  = rgbyuv_pkg::COMPONENT_W'(cr_sum >> 16);
      end
      beat.column     = column_position;
      beat.row        = row_position;
      beat.frame_last = last_column & last_row;
      if (last_column) begin
         column_position = '0;
         row_position    = last_row ? '0 : row_position + 1'b1;
      end else begin
         column_position = column_position + 1'b1;
      end
      return beat;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Result beats are checked first, then the pixel beat taken at the same edge
   // is predicted, so a result can never be matched with its own pixel.
   always @(posedge clock) begin
      yuv_beat_type          want;
      rgbyuv_pkg::pixel_type taken;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_yuv.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: result beat with none expected, actual luma %0d column %0d row %0d",
                     $time, rsp_bus.luma, rsp_bus.column, rsp_bus.row);
         end else begin
            want = expected_yuv.pop_front();
            compare_field("luma", want.luma, rsp_bus.luma);
            compare_field("chroma_blue", want.chroma_blue, rsp_bus.chroma_blue);
            compare_field("chroma_red", want.chroma_red, rsp_bus.chroma_red);
            compare_field("chroma_valid", want.chroma_valid, rsp_bus.chroma_valid);
            compare_field("column", want.column, rsp_bus.column);
            compare_field("row", want.row, rsp_bus.row);
            compare_field("frame_last", want.frame_last, rsp_bus.frame_last);
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         taken.red   = req_bus.red;
         taken.green = req_bus.green;
         taken.blue  = req_bus.blue;
         expected_yuv.push_back(convert_pixel(taken));
      end
   end

   // Receiver. Ready changes on the falling edge only. A hold-off request keeps
   // ready low for the whole long hold-off, counted here, before the random
   // back-pressure resumes.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_request = 1'b0;
         end else if (steady_flow) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: ends the run if neither channel moves a beat for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // Offers one pixel beat and returns on the falling edge after it has been
   // taken. Valid is left high so that back-to-back beats need no gap.
   task automatic send_pixel(input rgbyuv_pkg::pixel_type px);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.red   <= px.red;
      req_bus.green <= px.green;
      req_bus.blue  <= px.blue;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Closes a run of pixel beats by dropping valid.
   task automatic end_burst();
      req_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Dimension registers are only written once every result has come back and
   // the pipeline has had time to settle.
   task automatic write_register(input logic index, input int unsigned value);
      end_burst();
      while (expected_yuv.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= rgbyuv_pkg::DIM_REG_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == rgbyuv_pkg::CSR_LINE_WIDTH)
         line_width_shadow = rgbyuv_pkg::DIM_REG_W'(value);
      else
         frame_height_shadow = rgbyuv_pkg::DIM_REG_W'(value);
   endtask

   // Components lean towards the extremes, while still covering every value.
   function automatic rgbyuv_pkg::pixel_type random_pixel();
      rgbyuv_pkg::pixel_type              px;
      logic [rgbyuv_pkg::COMPONENT_W-1:0] part[3];
      foreach (part[i]) begin
         case ($urandom_range(0, 7))
            0:       part[i] = '0;
            1:       part[i] = '1;
            default: part[i] = rgbyuv_pkg::COMPONENT_W'($urandom_range(0, 255));
         endcase
      end
      px.red   = part[0];
      px.green = part[1];
      px.blue  = part[2];
      return px;
   endfunction

   // Mostly small frames so that lines and frames wrap often, with the odd
   // zero, full-size, oversize or medium dimension thrown in.
   function automatic int unsigned pick_dimension();
      case ($urandom_range(0, 15))
         0:       return 0;
         1:       return 1;
         2:       return DIMENSION_MAX;
         3:       return $urandom_range(DIMENSION_MAX + 1, 8191);
         4:       return $urandom_range(13, 200);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   // The reset values of 640 by 480 are in force before any write.
   task automatic test_reset_dimensions();
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
   endtask

   // With both dimensions at zero every pixel is a whole frame on its own.
   task automatic test_zero_dimensions();
      write_register(rgbyuv_pkg::CSR_LINE_WIDTH, 0);
      write_register(rgbyuv_pkg::CSR_FRAME_HEIGHT, 0);
      send_pixel(24'h123456);
      send_pixel(24'hEDCBA9);
   endtask

   // Four frames of two by two. The pixel at the odd column and odd row carries
   // the colour that drives one chroma component to its top or bottom value;
   // the others sweep luma between black and white.
   task automatic test_colour_extremes();
      logic [23:0] colours[16];
      colours = '{24'h000000, 24'hFFFFFF, 24'hAA55CC, 24'hFF0000,
                  24'hFFFFFF, 24'h000000, 24'h55AA33, 24'h0000FF,
                  24'h000000, 24'h808080, 24'h7F7F7F, 24'hFFFF00,
                  24'hFFFFFF, 24'h010101, 24'hFEFEFE, 24'h00FFFF};
      write_register(rgbyuv_pkg::CSR_LINE_WIDTH, 2);
      write_register(rgbyuv_pkg::CSR_FRAME_HEIGHT, 2);
      foreach (colours[i])
         send_pixel(colours[i]);
   endtask

   // Oversize values act as the largest supported size. Shrinking the width
   // past the current column, and later the height past the current row, ends
   // the line (and then the frame) on the next pixel.
   task automatic test_oversize_and_shrink();
      write_register(rgbyuv_pkg::CSR_LINE_WIDTH, 8191);
      write_register(rgbyuv_pkg::CSR_FRAME_HEIGHT, DIMENSION_MAX + 1);
      repeat (3) send_pixel(random_pixel());
      write_register(rgbyuv_pkg::CSR_LINE_WIDTH, 1);
      repeat (4) send_pixel(random_pixel());
      write_register(rgbyuv_pkg::CSR_FRAME_HEIGHT, 2);
      repeat (2) send_pixel(random_pixel());
   endtask

   // The receiver stops for a long stretch while pixels keep coming, so the
   // block must fill up and push back on its input.
   task automatic test_output_hold_off();
      write_register(rgbyuv_pkg::CSR_LINE_WIDTH, 3);
      write_register(rgbyuv_pkg::CSR_FRAME_HEIGHT, 3);
      hold_off_request = 1'b1;
      repeat (12) send_pixel(random_pixel());
   endtask

   // Random phases: each may pick new dimensions and streams a multiple of the
   // frame area where they are small, or a random run of pixels where they are large.
   task automatic test_random_frames();
      int unsigned sent;
      int unsigned phase;
      int unsigned area;
      int unsigned count;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         phase++;
         if ($urandom_range(0, 3) != 0)
            write_register(rgbyuv_pkg::CSR_LINE_WIDTH, pick_dimension());
         if ($urandom_range(0, 3) != 0)
            write_register(rgbyuv_pkg::CSR_FRAME_HEIGHT, pick_dimension());
         // One phase in the middle runs with no idling on either side.
         steady_flow = (phase == 5);
         area = clamp_dimension(line_width_shadow) * clamp_dimension(frame_height_shadow);
         if (steady_flow)
            count = 150;
         else if (area <= 60)
            count = area * $urandom_range(1, 3);
         else
            count = $urandom_range(20, 80);
         repeat (count) send_pixel(random_pixel());
         sent += count;
         end_burst();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = rgbyuv_pkg::CSR_LINE_WIDTH;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.red      = '0;
      req_bus.green    = '0;
      req_bus.blue     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_dimensions();
      test_zero_dimensions();
      test_colour_extremes();
      test_oversize_and_shrink();
      test_output_hold_off();
      test_random_frames();

      end_burst();
      while (expected_yuv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

[filelist.f]
design/rgbyuv_pkg.sv
design/rgbyuv_req_if.sv
design/rgbyuv_rsp_if.sv
design/rgbyuv_matrix.sv
design/rgb_to_yuv420_converter_unit.sv
verif/rgb_to_yuv420_converter_unit_test.sv
